// ===== rtl/core/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants of the physical frame allocator
// Field widths, operation, kind and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

  // Fixed widths of the request and result fields.
  localparam int OP_W       = 2;
  localparam int KIND_W     = 2;
  localparam int FRAME_W    = 10;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 11;
  localparam int LIMIT_W    = 11;

  // The in-use bitmap is kept as words of this many frames.
  localparam int WORD_BITS  = 32;
  localparam int WORD_SEL_W = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd512;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INC   = 2'd2,
    OP_DEC   = 2'd3
  } op_t;

  // Frame kinds; any code above KIND_DIR is rejected on allocate.
  localparam logic [KIND_W-1:0] KIND_PAGE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TABLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DIR   = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_INDEX  = 3'd1,
    ST_BAD_KIND   = 3'd2,
    ST_NO_FRAME   = 3'd3,
    ST_NOT_IN_USE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_LOOK  = 2'd2,
    S_MOD   = 2'd3
  } state_t;

endpackage : pfa_pkg

`default_nettype wire

// ===== rtl/core/physical_frame_allocator_core.sv =====
// ----------------------------------------------------------------------------
// physical_frame_allocator_core: first-fit frame allocator with ref counts
// Keeps an in-use bitmap, a kind and a reference count for every physical
// frame, plus running free, page, table and directory counts.
// ----------------------------------------------------------------------------
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------------
//   request  | in_valid / in_ready | op, frame_kind, frame_index
//   result   | out_valid/out_ready | status, result_frame, was_freed, counts
//   config   | cfg_wr_en           | cfg_wr_data (table_frame_limit)
//
// Every request passes through the accept cycle, a look-up cycle in which
// the shared lowest-zero finder picks the first non-full bitmap word (or the
// bitmap and metadata memories are read for the target frame), and an update
// cycle in which the same finder picks the bit inside the word and the
// memories are written back. The result register loads at the end of the
// update cycle, and in_ready returns in the same edge, so a new request can be
// accepted while the result still waits. The update cycle holds while an
// earlier result has not been taken. After reset a clearing pass over every
// bitmap word zeroes the bitmap memory; in_ready stays low during it, while
// configuration writes are taken.
`default_nettype none

module physical_frame_allocator_core
  import pfa_pkg::*;
#(
  parameter int NUM_FRAMES = 1024,
  parameter int REF_BITS   = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,

  input  wire logic                cfg_wr_en,
  input  wire logic [LIMIT_W-1:0]  cfg_wr_data,

  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [OP_W-1:0]     op,
  input  wire logic [KIND_W-1:0]   frame_kind,
  input  wire logic [FRAME_W-1:0]  frame_index,

  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STATUS_W-1:0]      status,
  output logic [FRAME_W-1:0]       result_frame,
  output logic                     was_freed,
  output logic [COUNT_W-1:0]       free_count,
  output logic [COUNT_W-1:0]       page_count,
  output logic [COUNT_W-1:0]       table_count,
  output logic [COUNT_W-1:0]       directory_count
);

  // Frame index width, bitmap geometry and a common compare width.
  localparam int FW     = $clog2(NUM_FRAMES);
  localparam int WORDS  = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int FFW    = WAW + WORD_SEL_W;
  localparam int LW     = $clog2(NUM_FRAMES + 1);
  localparam int AW0    = (FFW > LW) ? FFW : LW;
  localparam int AW     = (AW0 > LIMIT_W) ? AW0 : LIMIT_W;
  localparam int SW     = (WORDS > WORD_BITS) ? WORDS : WORD_BITS;
  localparam int SIW    = $clog2(SW);
  localparam int META_W = KIND_W + REF_BITS;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_t               state, state_next;
  logic [WAW-1:0]       clr_idx;
  logic [LIMIT_W-1:0]   limit_reg;

  // Request held for the duration of the operation.
  op_t                  req_op;
  logic [KIND_W-1:0]    req_kind;
  logic [FRAME_W-1:0]   req_idx;

  // Early rejection found in the look-up cycle.
  logic                 err_valid, err_valid_next;
  status_t              err_status, err_status_next;

  // Word and bit being worked on.
  logic [WAW-1:0]        word_addr, word_addr_next;
  logic [WORD_SEL_W-1:0] bit_sel, bit_sel_next;

  // Per-word "all frames in use" flags; they steer the word search.
  logic [WORDS-1:0]     full_bits, full_bits_next;

  // Running counts.
  logic [COUNT_W-1:0]   free_cnt, free_cnt_next;
  logic [COUNT_W-1:0]   page_cnt, page_cnt_next;
  logic [COUNT_W-1:0]   table_cnt, table_cnt_next;
  logic [COUNT_W-1:0]   dir_cnt, dir_cnt_next;

  // Result register.
  logic                 out_load;
  status_t              res_status;
  logic [FRAME_W-1:0]   res_frame;
  logic                 res_freed;

  // Memories: the in-use bitmap as words, and kind plus count per frame.
  logic [WORD_BITS-1:0] bitmap [WORDS];
  logic [META_W-1:0]    meta   [NUM_FRAMES];
  logic [WORD_BITS-1:0] rd_word;
  logic [META_W-1:0]    rd_meta;

  logic                 bm_rd_en, bm_we, meta_rd_en, meta_we;
  logic [WAW-1:0]       bm_rd_addr, bm_wr_addr;
  logic [WORD_BITS-1:0] bm_wdata;
  logic [FW-1:0]        meta_rd_addr, meta_wr_addr;
  logic [META_W-1:0]    meta_wdata;

  // Shared lowest-zero finder.
  logic [SW-1:0]        scan_vec;
  logic [SIW-1:0]       scan_idx;
  logic                 scan_found;

  pfa_scan #(
    .WIDTH (SW)
  ) u_scan (
    .vec      (scan_vec),
    .zero_idx (scan_idx),
    .found    (scan_found)
  );

  // --------------------------------------------------------------------------
  // Derived values
  // --------------------------------------------------------------------------
  logic [AW-1:0]        idx_ext, nf_ext, cfg_ext, alloc_limit, f_ext;
  logic [WORD_SEL_W-1:0] alloc_bit;
  logic [WORD_BITS-1:0] alloc_mask, idx_mask;
  logic [REF_BITS-1:0]  cur_cnt, dec_cnt;
  logic [KIND_W-1:0]    cur_kind;
  logic                 in_use;

  assign idx_ext  = AW'(req_idx);
  assign nf_ext   = AW'(NUM_FRAMES);
  assign cfg_ext  = AW'(limit_reg);

  // Data pages may use every frame; tables and directories stop at the limit,
  // which itself never reaches past the end of the table.
  assign alloc_limit = (req_kind != KIND_PAGE && cfg_ext < nf_ext) ? cfg_ext : nf_ext;

  assign alloc_bit  = scan_idx[WORD_SEL_W-1:0];
  assign f_ext      = AW'({word_addr, alloc_bit});
  assign alloc_mask = WORD_BITS'(1) << alloc_bit;
  assign idx_mask   = WORD_BITS'(1) << bit_sel;

  assign cur_cnt  = rd_meta[REF_BITS-1:0];
  assign cur_kind = rd_meta[META_W-1:REF_BITS];
  assign dec_cnt  = (cur_cnt != '0) ? cur_cnt - REF_BITS'(1) : cur_cnt;
  assign in_use   = rd_word[bit_sel];

  // The finder sees the word flags while looking up and the bitmap word while
  // updating; unused positions read as taken.
  always_comb begin
    scan_vec = '1;
    if (state == S_LOOK) begin
      scan_vec[WORDS-1:0] = full_bits;
    end else begin
      scan_vec[WORD_BITS-1:0] = rd_word;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    err_valid_next  = err_valid;
    err_status_next = err_status;
    word_addr_next  = word_addr;
    bit_sel_next    = bit_sel;
    full_bits_next  = full_bits;
    free_cnt_next   = free_cnt;
    page_cnt_next   = page_cnt;
    table_cnt_next  = table_cnt;
    dir_cnt_next    = dir_cnt;

    bm_rd_en     = 1'b0;
    bm_we        = 1'b0;
    bm_wr_addr   = word_addr;
    bm_wdata     = rd_word;
    meta_rd_en   = 1'b0;
    meta_rd_addr = idx_ext[FW-1:0];
    meta_we      = 1'b0;
    meta_wr_addr = idx_ext[FW-1:0];
    meta_wdata   = rd_meta;

    out_load   = 1'b0;
    res_status = ST_OK;
    res_frame  = req_idx;
    res_freed  = 1'b0;

    unique case (state)
      S_CLEAR: begin
        bm_we      = 1'b1;
        bm_wr_addr = clr_idx;
        bm_wdata   = '0;
        if (clr_idx == WAW'(WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          state_next = S_LOOK;
        end
      end

      S_LOOK: begin
        err_valid_next  = 1'b0;
        err_status_next = ST_OK;
        if (req_op == OP_ALLOC) begin
          if (req_kind > KIND_DIR) begin
            err_valid_next  = 1'b1;
            err_status_next = ST_BAD_KIND;
          end else if (!scan_found) begin
            err_valid_next  = 1'b1;
            err_status_next = ST_NO_FRAME;
          end else begin
            word_addr_next = scan_idx[WAW-1:0];
            bm_rd_en       = 1'b1;
          end
        end else if (idx_ext >= nf_ext) begin
          err_valid_next  = 1'b1;
          err_status_next = ST_BAD_INDEX;
        end else begin
          word_addr_next = idx_ext[WAW+WORD_SEL_W-1:WORD_SEL_W];
          bit_sel_next   = idx_ext[WORD_SEL_W-1:0];
          bm_rd_en       = 1'b1;
          meta_rd_en     = 1'b1;
        end
        state_next = S_MOD;
      end

      S_MOD: begin
        // Hold here until the result register is free.
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          if (err_valid) begin
            res_status = err_status;
            if (req_op == OP_ALLOC) begin
              res_frame = '0;
            end
          end else if (req_op == OP_ALLOC) begin
            if (f_ext < alloc_limit) begin
              bm_we                     = 1'b1;
              bm_wdata                  = rd_word | alloc_mask;
              full_bits_next[word_addr] = &(rd_word | alloc_mask);
              meta_we                   = 1'b1;
              meta_wr_addr              = f_ext[FW-1:0];
              meta_wdata                = {req_kind, REF_BITS'(0)};
              free_cnt_next             = free_cnt - COUNT_W'(1);
              if (req_kind == KIND_PAGE) begin
                page_cnt_next = page_cnt + COUNT_W'(1);
              end else if (req_kind == KIND_TABLE) begin
                table_cnt_next = table_cnt + COUNT_W'(1);
              end else begin
                dir_cnt_next = dir_cnt + COUNT_W'(1);
              end
              res_frame = f_ext[FRAME_W-1:0];
            end else begin
              // The lowest free frame lies at or beyond the limit.
              res_status = ST_NO_FRAME;
              res_frame  = '0;
            end
          end else if (!in_use) begin
            res_status = ST_NOT_IN_USE;
          end else begin
            meta_wr_addr = idx_ext[FW-1:0];
            // A free, or a decrement that ends at zero, releases the frame.
            if (req_op == OP_FREE || (req_op == OP_DEC && dec_cnt == '0)) begin
              bm_we                     = 1'b1;
              bm_wdata                  = rd_word & ~idx_mask;
              full_bits_next[word_addr] = 1'b0;
              free_cnt_next             = free_cnt + COUNT_W'(1);
              if (cur_kind == KIND_PAGE) begin
                page_cnt_next = page_cnt - COUNT_W'(1);
              end else if (cur_kind == KIND_TABLE) begin
                table_cnt_next = table_cnt - COUNT_W'(1);
              end else begin
                dir_cnt_next = dir_cnt - COUNT_W'(1);
              end
              res_freed = (req_op == OP_DEC);
            end else if (req_op == OP_INC) begin
              meta_we = 1'b1;
              meta_wdata = {cur_kind,
                            (cur_cnt != '1) ? cur_cnt + REF_BITS'(1) : cur_cnt};
            end else begin
              meta_we    = 1'b1;
              meta_wdata = {cur_kind, dec_cnt};
            end
          end
        end
      end

      default: begin
        state_next = S_CLEAR;
      end
    endcase

    // The bitmap is read at the word chosen in this cycle.
    bm_rd_addr = word_addr_next;
  end

  assign in_ready = (state == S_IDLE);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx   <= '0;
      limit_reg <= LIMIT_RESET;
      err_valid <= 1'b0;
      full_bits <= '0;
      free_cnt  <= COUNT_W'(NUM_FRAMES);
      page_cnt  <= '0;
      table_cnt <= '0;
      dir_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + WAW'(1);
      end
      if (cfg_wr_en) begin
        limit_reg <= cfg_wr_data;
      end
      err_valid <= err_valid_next;
      full_bits <= full_bits_next;
      free_cnt  <= free_cnt_next;
      page_cnt  <= page_cnt_next;
      table_cnt <= table_cnt_next;
      dir_cnt   <= dir_cnt_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_op   <= op_t'(op);
      req_kind <= frame_kind;
      req_idx  <= frame_index;
    end
    err_status <= err_status_next;
    word_addr  <= word_addr_next;
    bit_sel    <= bit_sel_next;
    if (out_load) begin
      status       <= res_status;
      result_frame <= res_frame;
      was_freed    <= res_freed;
    end
  end

  always_ff @(posedge clk) begin
    if (bm_we) begin
      bitmap[bm_wr_addr] <= bm_wdata;
    end
    if (bm_rd_en) begin
      rd_word <= bitmap[bm_rd_addr];
    end
  end

  // Metadata is written on allocate and is only used for frames in use, so it
  // needs no clearing pass.
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta[meta_wr_addr] <= meta_wdata;
    end
    if (meta_rd_en) begin
      rd_meta <= meta[meta_rd_addr];
    end
  end

  // The counters change only together with a result load, so they are shown
  // directly.
  assign free_count      = free_cnt;
  assign page_count      = page_cnt;
  assign table_count     = table_cnt;
  assign directory_count = dir_cnt;

endmodule : physical_frame_allocator_core

`default_nettype wire

// ===== rtl/core/pfa_scan.sv =====
// ----------------------------------------------------------------------------
// pfa_scan: lowest-zero finder
// Returns the position of the lowest clear bit of a vector and whether any
// bit is clear. Shared by the word search and the bit search.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_scan #(
  parameter int WIDTH = 32
) (
  input  wire logic [WIDTH-1:0]         vec,
  output logic      [$clog2(WIDTH)-1:0] zero_idx,
  output logic                          found
);

  always_comb begin
    zero_idx = '0;
    found    = 1'b0;
    // Walking down from the top leaves the lowest clear bit in zero_idx.
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (!vec[i]) begin
        zero_idx = ($clog2(WIDTH))'(i);
        found    = 1'b1;
      end
    end
  end

endmodule : pfa_scan

`default_nettype wire

// ===== rtl/core/pfa_checker.sv =====
// ----------------------------------------------------------------------------
// pfa_checker: port-level checks of the frame allocator
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_checker
  import pfa_pkg::*;
#(
  parameter int NUM_FRAMES = 1024
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [STATUS_W-1:0] status,
  input wire logic [FRAME_W-1:0]  result_frame,
  input wire logic                was_freed,
  input wire logic [COUNT_W-1:0]  free_count,
  input wire logic [COUNT_W-1:0]  page_count,
  input wire logic [COUNT_W-1:0]  table_count,
  input wire logic [COUNT_W-1:0]  directory_count
);

  logic [COUNT_W-1:0] total;
  assign total = free_count + page_count + table_count + directory_count;

  // Every frame is counted exactly once.
  a_conserve: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> total == COUNT_W'(NUM_FRAMES))
    else $error("frame counts do not add up to the table size");

  // One transfer at a time: the request side closes after a transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in progress");

  // An allocation that finds no frame reports frame zero.
  a_no_frame_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_NO_FRAME) |-> result_frame == '0)
    else $error("no-frame result carries a frame index");

  // The freed flag is only set by a successful decrement.
  a_freed_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && was_freed) |-> status == ST_OK)
    else $error("freed flag set on a failed operation");

  // A stalled result holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(status)
                                  && $stable(result_frame) && $stable(free_count))
    else $error("stalled result changed");

endmodule : pfa_checker

bind physical_frame_allocator_core pfa_checker #(
  .NUM_FRAMES (NUM_FRAMES)
) u_pfa_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .status          (status),
  .result_frame    (result_frame),
  .was_freed       (was_freed),
  .free_count      (free_count),
  .page_count      (page_count),
  .table_count     (table_count),
  .directory_count (directory_count)
);

`default_nettype wire
